// ===== sv/aprs_pkg.sv =====
// ----------------------------------------------------------------------------
// aprs_pkg
// Types and constants shared by the ATA PIO read sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aprs_pkg;

   localparam int unsigned WORDS       = 256;
   localparam int unsigned ID_WORDS    = 256;
   localparam int unsigned MAX_RESULTS = 7;

   localparam logic [47:0] LBA28_MAX = 48'h0000_0FFF_FFFF;

   localparam logic [7:0] SR_BSY = 8'h80;
   localparam logic [7:0] SR_DRQ = 8'h08;
   localparam logic [7:0] SR_ERR = 8'h01;

   localparam logic [7:0] DEV_LBA    = 8'hE0;
   localparam logic [7:0] DEV_MASTER = 8'hA0;
   localparam logic [7:0] CMD_READ   = 8'h20;
   localparam logic [7:0] CMD_IDENT  = 8'hEC;

   localparam logic [1:0] OP_READ     = 2'd0;
   localparam logic [1:0] OP_IDENTIFY = 2'd1;
   localparam logic [1:0] OP_RESPONSE = 2'd2;

   localparam logic [1:0] K_WRITE = 2'd0;
   localparam logic [1:0] K_READ  = 2'd1;
   localparam logic [1:0] K_WORD  = 2'd2;
   localparam logic [1:0] K_DONE  = 2'd3;

   localparam logic [2:0] REG_DATA    = 3'd0;
   localparam logic [2:0] REG_COUNT   = 3'd2;
   localparam logic [2:0] REG_LBA_LO  = 3'd3;
   localparam logic [2:0] REG_LBA_MID = 3'd4;
   localparam logic [2:0] REG_LBA_HI  = 3'd5;
   localparam logic [2:0] REG_DEVICE  = 3'd6;
   localparam logic [2:0] REG_STATUS  = 3'd7;

   localparam logic [2:0] DC_OK        = 3'd0;
   localparam logic [2:0] DC_RANGE     = 3'd1;
   localparam logic [2:0] DC_READ_ERR  = 3'd2;
   localparam logic [2:0] DC_NO_DEVICE = 3'd3;
   localparam logic [2:0] DC_ID_FAIL   = 3'd4;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_RD_BSY   = 3'd1;
   localparam logic [2:0] PH_RD_DRQ   = 3'd2;
   localparam logic [2:0] PH_RD_DATA  = 3'd3;
   localparam logic [2:0] PH_ID_FIRST = 3'd4;
   localparam logic [2:0] PH_ID_POLL  = 3'd5;
   localparam logic [2:0] PH_ID_DATA  = 3'd6;

   typedef struct packed {
      logic [1:0]  op;
      logic [47:0] lba;
      logic [15:0] response_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  reg_offset;
      logic [15:0] value;
      logic [2:0]  done_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]                   count;
      rsp_type [MAX_RESULTS-1:0]    entry;
   } batch_type;

   function automatic rsp_type mk_rsp(logic [1:0] kind, logic [2:0] reg_offset,
                                      logic [15:0] value, logic [2:0] done_code);
      rsp_type r;
      r.kind       = kind;
      r.reg_offset = reg_offset;
      r.value      = value;
      r.done_code  = done_code;
      r.last       = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/aprs_sequencer.sv =====
// ----------------------------------------------------------------------------
// aprs_sequencer
// Input register, protocol phase state and decode of one input word into
// the batch of results that it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module aprs_sequencer (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  aprs_pkg::req_type       req_payload,
   input  wire                     issue_free,
   output logic                    batch_valid,
   output aprs_pkg::batch_type     batch
);

   logic                a_valid_ff, a_valid_in;
   aprs_pkg::req_type   a_req_ff,   a_req_in;
   logic [2:0]          phase_ff,   phase_in;
   logic [8:0]          wc_ff,      wc_in;
   logic                a_take;
   logic [8:0]          wc_inc;
   logic [7:0]          st;
   logic [47:0]         lba;
   aprs_pkg::batch_type b;

   assign st     = a_req_ff.response_data[7:0];
   assign lba    = a_req_ff.lba;
   assign wc_inc = wc_ff + 9'd1;

   always_comb begin
      b        = '0;
      phase_in = phase_ff;
      wc_in    = wc_ff;
      if (a_req_ff.op == aprs_pkg::OP_READ || a_req_ff.op == aprs_pkg::OP_IDENTIFY) begin
         if (phase_ff == aprs_pkg::PH_IDLE) begin
            if (a_req_ff.op == aprs_pkg::OP_READ && lba > aprs_pkg::LBA28_MAX) begin
               b.count    = 3'd1;
               b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_DONE, aprs_pkg::REG_DATA, 16'd0,
                                             aprs_pkg::DC_RANGE);
            end else if (a_req_ff.op == aprs_pkg::OP_READ) begin
               b.count    = 3'd7;
               b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_DEVICE,
                               {8'd0, aprs_pkg::DEV_LBA | {4'd0, lba[27:24]}}, aprs_pkg::DC_OK);
               b.entry[1] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_COUNT,
                               16'd1, aprs_pkg::DC_OK);
               b.entry[2] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_LBA_LO,
                               {8'd0, lba[7:0]}, aprs_pkg::DC_OK);
               b.entry[3] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_LBA_MID,
                               {8'd0, lba[15:8]}, aprs_pkg::DC_OK);
               b.entry[4] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_LBA_HI,
                               {8'd0, lba[23:16]}, aprs_pkg::DC_OK);
               b.entry[5] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_STATUS,
                               {8'd0, aprs_pkg::CMD_READ}, aprs_pkg::DC_OK);
               b.entry[6] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                               16'd0, aprs_pkg::DC_OK);
               phase_in   = aprs_pkg::PH_RD_BSY;
            end else begin
               b.count    = 3'd7;
               b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_DEVICE,
                               {8'd0, aprs_pkg::DEV_MASTER}, aprs_pkg::DC_OK);
               b.entry[1] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_COUNT,
                               16'd0, aprs_pkg::DC_OK);
               b.entry[2] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_LBA_LO,
                               16'd0, aprs_pkg::DC_OK);
               b.entry[3] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_LBA_MID,
                               16'd0, aprs_pkg::DC_OK);
               b.entry[4] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_LBA_HI,
                               16'd0, aprs_pkg::DC_OK);
               b.entry[5] = aprs_pkg::mk_rsp(aprs_pkg::K_WRITE, aprs_pkg::REG_STATUS,
                               {8'd0, aprs_pkg::CMD_IDENT}, aprs_pkg::DC_OK);
               b.entry[6] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                               16'd0, aprs_pkg::DC_OK);
               phase_in   = aprs_pkg::PH_ID_FIRST;
            end
         end
      end else if (a_req_ff.op == aprs_pkg::OP_RESPONSE) begin
         case (phase_ff)
            aprs_pkg::PH_RD_BSY: begin
               b.count = 3'd1;
               if ((st & aprs_pkg::SR_BSY) != 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                                                16'd0, aprs_pkg::DC_OK);
               end else if ((st & aprs_pkg::SR_ERR) != 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_DONE, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_READ_ERR);
                  phase_in   = aprs_pkg::PH_IDLE;
               end else begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                                                16'd0, aprs_pkg::DC_OK);
                  phase_in   = aprs_pkg::PH_RD_DRQ;
               end
            end
            aprs_pkg::PH_RD_DRQ: begin
               b.count = 3'd1;
               if ((st & aprs_pkg::SR_DRQ) != 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = 9'd0;
                  phase_in   = aprs_pkg::PH_RD_DATA;
               end else begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                                                16'd0, aprs_pkg::DC_OK);
               end
            end
            aprs_pkg::PH_RD_DATA: begin
               b.count    = 3'd2;
               b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_WORD, aprs_pkg::REG_DATA,
                                             a_req_ff.response_data, aprs_pkg::DC_OK);
               if (wc_inc >= 9'(aprs_pkg::WORDS)) begin
                  b.entry[1] = aprs_pkg::mk_rsp(aprs_pkg::K_DONE, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = 9'd0;
                  phase_in   = aprs_pkg::PH_IDLE;
               end else begin
                  b.entry[1] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = wc_inc;
               end
            end
            aprs_pkg::PH_ID_FIRST: begin
               b.count = 3'd1;
               if (st == 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_DONE, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_NO_DEVICE);
                  phase_in   = aprs_pkg::PH_IDLE;
               end else if ((st & (aprs_pkg::SR_DRQ | aprs_pkg::SR_ERR)) != 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = 9'd0;
                  phase_in   = aprs_pkg::PH_ID_DATA;
               end else begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                                                16'd0, aprs_pkg::DC_OK);
                  phase_in   = aprs_pkg::PH_ID_POLL;
               end
            end
            aprs_pkg::PH_ID_POLL: begin
               b.count = 3'd1;
               if ((st & aprs_pkg::SR_ERR) != 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_DONE, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_ID_FAIL);
                  phase_in   = aprs_pkg::PH_IDLE;
               end else if ((st & aprs_pkg::SR_DRQ) != 8'd0) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = 9'd0;
                  phase_in   = aprs_pkg::PH_ID_DATA;
               end else begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_STATUS,
                                                16'd0, aprs_pkg::DC_OK);
               end
            end
            aprs_pkg::PH_ID_DATA: begin
               b.count = 3'd1;
               if (wc_inc >= 9'(aprs_pkg::ID_WORDS)) begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_DONE, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = 9'd0;
                  phase_in   = aprs_pkg::PH_IDLE;
               end else begin
                  b.entry[0] = aprs_pkg::mk_rsp(aprs_pkg::K_READ, aprs_pkg::REG_DATA,
                                                16'd0, aprs_pkg::DC_OK);
                  wc_in      = wc_inc;
               end
            end
            default: begin
               b.count = 3'd0;
            end
         endcase
      end
      for (int i = 0; i < aprs_pkg::MAX_RESULTS; i++) begin
         b.entry[i].last = (b.count != 3'd0) && (3'(i) == b.count - 3'd1);
      end
   end

   assign a_take      = a_valid_ff && (b.count == 3'd0 || issue_free);
   assign req_ready   = !a_valid_ff || a_take;
   assign batch_valid = a_take && b.count != 3'd0;
   assign batch       = b;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_req_in   = a_req_ff;
      if (req_valid && req_ready) begin
         a_valid_in = 1'b1;
         a_req_in   = req_payload;
      end else if (a_take) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff <= a_req_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
         phase_ff   <= aprs_pkg::PH_IDLE;
         wc_ff      <= 9'd0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (a_take) begin
            phase_ff <= phase_in;
            wc_ff    <= wc_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/aprs_issue.sv =====
// ----------------------------------------------------------------------------
// aprs_issue
// Holds one batch of results and hands them to the output register one
// word per cycle, in order, while the receiver does not stall the output.
// ----------------------------------------------------------------------------
`default_nettype none

module aprs_issue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     batch_valid,
   input  aprs_pkg::batch_type     batch,
   output logic                    issue_free,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output aprs_pkg::rsp_type       rsp_payload
);

   logic                b_valid_ff, b_valid_in;
   aprs_pkg::batch_type batch_ff,   batch_in;
   logic [2:0]          idx_ff,     idx_in;
   logic                o_valid_ff, o_valid_in;
   aprs_pkg::rsp_type   o_ff,       o_in;
   logic                push;
   logic                last_push;

   assign push       = b_valid_ff && (!o_valid_ff || rsp_ready);
   assign last_push  = push && (idx_ff == batch_ff.count - 3'd1);
   assign issue_free = !b_valid_ff || last_push;

   always_comb begin
      b_valid_in = b_valid_ff;
      batch_in   = batch_ff;
      idx_in     = idx_ff;
      if (batch_valid) begin
         b_valid_in = 1'b1;
         batch_in   = batch;
         idx_in     = 3'd0;
      end else if (last_push) begin
         b_valid_in = 1'b0;
      end else if (push) begin
         idx_in = idx_ff + 3'd1;
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      o_in       = o_ff;
      if (push) begin
         o_valid_in = 1'b1;
         o_in       = batch_ff.entry[idx_ff];
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      batch_ff <= batch_in;
      o_ff     <= o_in;
      if (reset) begin
         b_valid_ff <= 1'b0;
         idx_ff     <= 3'd0;
         o_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         idx_ff     <= idx_in;
         o_valid_ff <= o_valid_in;
      end
   end

   assign rsp_valid   = o_valid_ff;
   assign rsp_payload = o_ff;

endmodule

`default_nettype wire

// ===== sv/ata_pio_read_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// ata_pio_read_sequencer_unit
// Host-side ATA PIO sequencer for LBA28 sector reads and device identify.
//
// The req channel carries read requests, identify requests and the answers
// to bus reads that this block asked for. The rsp channel carries taskfile
// register writes, register read requests, sector data words and done codes;
// last marks the final word caused by one request word.
// Both channels use valid and ready. A request word sits in an input
// register while its results are decoded into a batch of up to seven
// words, which then leaves through an output register one word per cycle
// while the receiver does not stall. The first result passes through the input
// register, the batch buffer and the output register. A new batch enters the
// buffer as the last word of the current one moves to the output register;
// each data word of a sector transfer causes two results, a command seven.
// When the receiver stalls, the output register holds its word, the batch
// buffer fills and req_ready falls; nothing is lost or repeated.
// Reset empties all registers and returns the protocol to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_pio_read_sequencer_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  aprs_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output aprs_pkg::rsp_type   rsp_payload
);

   logic                issue_free;
   logic                batch_valid;
   aprs_pkg::batch_type batch;

   aprs_sequencer u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .issue_free  (issue_free),
      .batch_valid (batch_valid),
      .batch       (batch)
   );

   aprs_issue u_issue (
      .clock       (clock),
      .reset       (reset),
      .batch_valid (batch_valid),
      .batch       (batch),
      .issue_free  (issue_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
